FILE: rtl/bwts_pkg.sv
`timescale 1ns / 1ps
package bwts_pkg;

   typedef enum logic [1:0] {
      CMD_WRITE_RGBA = 2'd0,
      CMD_READ       = 2'd1,
      CMD_SAMPLE     = 2'd2,
      CMD_WRITE_BGRA = 2'd3
   } cmd_type;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   localparam logic [7:0] OPAQUE_ALPHA = 8'd255;

   typedef struct packed {
      logic       is_read;
      logic       is_sample;
      logic       miss;
      logic [7:0] fu;
      logic [7:0] fv;
   } ctl_type;

   function automatic logic [15:0] lerp_w(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] f);
      logic [8:0] g;
      g = 9'd256 - {1'b0, f};
      return 16'(a * g) + 16'(b * f);
   endfunction

endpackage

FILE: rtl/bilinear_wrap_texture_sampler_top.sv
`timescale 1ns / 1ps
// Channel | Valid      | Stall      | Payload
// req     | req_valid  | req_stall  | command tex_x tex_y in_* coord_u coord_v
// rsp     | rsp_valid  | rsp_stall  | out_red out_green out_blue out_alpha miss
// csr     | csr_valid  | csr_ready  | csr_index csr_data (ready always high)
// One item per cycle while not stalled; rsp_valid rises once the req has passed every stage.
// Four store copies, each written on in-range writes, give four reads per unstalled cycle.
// Every stage moves only when the output stage is free; a stall freezes all stages.
// Reset clears valid bits and sets both sizes to 256; the store is not cleared.
module bilinear_wrap_texture_sampler_top #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_tex_x,
   input  logic [7:0]  req_tex_y,
   input  logic [7:0]  req_in_red,
   input  logic [7:0]  req_in_green,
   input  logic [7:0]  req_in_blue,
   input  logic [7:0]  req_in_alpha,
   input  logic [15:0] req_coord_u,
   input  logic [15:0] req_coord_v,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_red,
   output logic [7:0]  rsp_out_green,
   output logic [7:0]  rsp_out_blue,
   output logic [7:0]  rsp_out_alpha,
   output logic        rsp_miss,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [8:0]  csr_data
);

   localparam int XW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
   localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int SW = $clog2(MAX_WIDTH + 1) > 9 ? $clog2(MAX_WIDTH + 1) : 9;
   localparam int TW = $clog2(MAX_HEIGHT + 1) > 9 ? $clog2(MAX_HEIGHT + 1) : 9;
   localparam int TDEPTH = (1 << XW) * (1 << YW);
   localparam int AW = XW + YW;

   logic [8:0] width_ff, height_ff;
   logic [SW-1:0] w_eff;
   logic [TW-1:0] h_eff;
   logic adv;

   assign adv = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 9'd256;
         height_ff <= 9'd256;
      end else if (csr_valid) begin
         if (csr_index == bwts_pkg::CSR_WIDTH) width_ff <= csr_data;
         else height_ff <= csr_data;
      end
   end

   always_comb begin
      if (width_ff == 9'd0) w_eff = SW'(1);
      else if (SW'(width_ff) > SW'(MAX_WIDTH)) w_eff = SW'(MAX_WIDTH);
      else w_eff = SW'(width_ff);
      if (height_ff == 9'd0) h_eff = TW'(1);
      else if (TW'(height_ff) > TW'(MAX_HEIGHT)) h_eff = TW'(MAX_HEIGHT);
      else h_eff = TW'(height_ff);
   end

   // stage 1: scale coordinates, range checks
   logic        s1_v_ff;
   logic [1:0]  s1_cmd_ff;
   logic [7:0]  s1_x_ff, s1_y_ff;
   logic [31:0] s1_data_ff;
   logic [SW+15:0] s1_px_ff;
   logic [TW+15:0] s1_py_ff;
   logic [SW-1:0] s1_w_ff;
   logic [TW-1:0] s1_h_ff;
   logic        s1_oob_ff;
   logic        wr_bgra;
   logic [31:0] wr_word;

   assign wr_bgra = req_command == bwts_pkg::CMD_WRITE_BGRA;
   assign wr_word = {req_in_alpha, wr_bgra ? req_in_red : req_in_blue, req_in_green,
                     wr_bgra ? req_in_blue : req_in_red};

   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else if (adv) s1_v_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_cmd_ff  <= req_command;
         s1_x_ff    <= req_tex_x;
         s1_y_ff    <= req_tex_y;
         s1_data_ff <= wr_word;
         s1_px_ff   <= (SW+16)'(req_coord_u * w_eff);
         s1_py_ff   <= (TW+16)'(req_coord_v * h_eff);
         s1_w_ff    <= w_eff;
         s1_h_ff    <= h_eff;
         s1_oob_ff  <= (SW'(req_tex_x) >= w_eff) || (TW'(req_tex_y) >= h_eff);
      end
   end

   // stage 2: neighbor coordinates, store reads, writes
   logic [SW-1:0] x0, x1p, x1;
   logic [TW-1:0] y0, y1p, y1;
   logic s1_is_wr, s1_do_wr;

   always_comb begin
      x0  = SW'(s1_px_ff >> 16);
      y0  = TW'(s1_py_ff >> 16);
      x1p = x0 + SW'(1);
      y1p = y0 + TW'(1);
      x1  = (x1p == s1_w_ff) ? '0 : x1p;
      y1  = (y1p == s1_h_ff) ? '0 : y1p;
      if (s1_cmd_ff != bwts_pkg::CMD_SAMPLE) begin
         x0 = SW'(s1_x_ff);
         y0 = TW'(s1_y_ff);
         x1 = x0;
         y1 = y0;
      end
   end

   assign s1_is_wr = s1_cmd_ff == bwts_pkg::CMD_WRITE_RGBA ||
                     s1_cmd_ff == bwts_pkg::CMD_WRITE_BGRA;
   assign s1_do_wr = adv && s1_v_ff && s1_is_wr && !s1_oob_ff;

   logic [31:0] mem00 [TDEPTH];
   logic [31:0] mem10 [TDEPTH];
   logic [31:0] mem01 [TDEPTH];
   logic [31:0] mem11 [TDEPTH];
   logic [AW-1:0] addr00, addr10, addr01, addr11, waddr;
   logic [31:0] rd00_ff, rd10_ff, rd01_ff, rd11_ff;

   always_comb begin
      addr00 = {YW'(y0), XW'(x0)};
      addr10 = {YW'(y0), XW'(x1)};
      addr01 = {YW'(y1), XW'(x0)};
      addr11 = {YW'(y1), XW'(x1)};
      waddr  = {YW'(s1_y_ff), XW'(s1_x_ff)};
   end

   always_ff @(posedge clock) begin
      if (s1_do_wr) begin
         mem00[waddr] <= s1_data_ff;
         mem10[waddr] <= s1_data_ff;
         mem01[waddr] <= s1_data_ff;
         mem11[waddr] <= s1_data_ff;
      end
      if (adv) begin
         rd00_ff <= mem00[addr00];
         rd10_ff <= mem10[addr10];
         rd01_ff <= mem01[addr01];
         rd11_ff <= mem11[addr11];
      end
   end

   logic s2_v_ff;
   bwts_pkg::ctl_type s2_ctl_ff, s3_ctl_ff, s4_ctl_ff;
   logic s3_v_ff, s4_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else if (adv) begin
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ctl_ff.is_read   <= s1_cmd_ff == bwts_pkg::CMD_READ;
         s2_ctl_ff.is_sample <= s1_cmd_ff == bwts_pkg::CMD_SAMPLE;
         s2_ctl_ff.miss      <= (s1_cmd_ff != bwts_pkg::CMD_SAMPLE) && s1_oob_ff;
         s2_ctl_ff.fu        <= s1_px_ff[15:8];
         s2_ctl_ff.fv        <= s1_py_ff[15:8];
      end
   end

   // stage 3: horizontal blend
   logic [31:0] c00, c10, c01, c11;
   logic [15:0] top_ff [4];
   logic [15:0] bot_ff [4];

   assign c00 = rd00_ff;
   assign c10 = rd10_ff;
   assign c01 = rd01_ff;
   assign c11 = rd11_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_ctl_ff <= s2_ctl_ff;
         for (int k = 0; k < 4; k++) begin
            top_ff[k] <= s2_ctl_ff.is_sample ?
               bwts_pkg::lerp_w(c00[8*k +: 8], c10[8*k +: 8], s2_ctl_ff.fu) :
               {c00[8*k +: 8], 8'd0};
            bot_ff[k] <= bwts_pkg::lerp_w(c01[8*k +: 8], c11[8*k +: 8], s2_ctl_ff.fu);
         end
      end
   end

   // stage 4: vertical blend
   logic [7:0] s4_col_ff [4];
   logic [24:0] vsum [4];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         vsum[k] = 25'(top_ff[k] * (9'd256 - {1'b0, s3_ctl_ff.fv}))
                 + 25'(bot_ff[k] * s3_ctl_ff.fv) + 25'd32768;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_ctl_ff <= s3_ctl_ff;
         for (int k = 0; k < 4; k++) begin
            if (s3_ctl_ff.is_sample) s4_col_ff[k] <= vsum[k][23:16];
            else s4_col_ff[k] <= top_ff[k][15:8];
         end
      end
   end

   // stage 5: output register
   logic [7:0] out_r_ff, out_g_ff, out_b_ff, out_a_ff;
   logic out_miss_ff, out_v_ff;
   logic s4_rd_ok;

   assign s4_rd_ok = s4_ctl_ff.is_sample || (s4_ctl_ff.is_read && !s4_ctl_ff.miss);

   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (adv) out_v_ff <= s4_v_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_r_ff    <= s4_rd_ok ? s4_col_ff[0] : 8'd0;
         out_g_ff    <= s4_rd_ok ? s4_col_ff[1] : 8'd0;
         out_b_ff    <= s4_rd_ok ? s4_col_ff[2] : 8'd0;
         out_a_ff    <= s4_rd_ok ? s4_col_ff[3] :
                        ((s4_ctl_ff.is_read && s4_ctl_ff.miss) ? bwts_pkg::OPAQUE_ALPHA : 8'd0);
         out_miss_ff <= s4_ctl_ff.miss;
      end
   end

   assign rsp_valid     = out_v_ff;
   assign rsp_out_red   = out_r_ff;
   assign rsp_out_green = out_g_ff;
   assign rsp_out_blue  = out_b_ff;
   assign rsp_out_alpha = out_a_ff;
   assign rsp_miss      = out_miss_ff;

`ifndef NO_ASSERTIONS
   a_miss_not_sample: assert property (@(posedge clock) disable iff (reset)
      s4_v_ff && s4_ctl_ff.is_sample |-> !s4_ctl_ff.miss)
      else $error("sample flagged miss");
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_alpha) && $stable(rsp_miss))
      else $error("result changed under stall");
   a_read_miss_alpha: assert property (@(posedge clock) disable iff (reset)
      s4_v_ff && adv && s4_ctl_ff.is_read && s4_ctl_ff.miss |=> rsp_out_alpha == 8'd255)
      else $error("missed read not opaque");
   a_wrap_bound: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && s1_cmd_ff == bwts_pkg::CMD_SAMPLE |-> x1 < s1_w_ff && y1 < s1_h_ff)
      else $error("neighbor outside texture");
`endif

endmodule
